FILE: hw/rtl/pfp_pkg.sv
// ----------------------------------------------------------------------------
// pfp_pkg
// Shared types and constants for the postorder-from-trace block.
// ----------------------------------------------------------------------------
package pfp_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int VAL_W       = 16;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_POP    = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  typedef struct packed {
    logic [1:0]       mode;
    logic [VAL_W-1:0] node_value_in;
  } in_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] node_value;
    logic             last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic             mark;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic set_mark;
  } shift_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_FLUSH
  } state_t;

endpackage

FILE: hw/rtl/postorder_from_push_pop_trace.sv
// Push: accepted while idle and stays ready; pop and finish hold in_ready low.
// Pop with k marked entries on top: k results at one per cycle while the output
// is not stalled, then the new top is marked. Finish on n entries: n results.
// Rate is set by the stack cell row, which shifts one slot per cycle unless stalled.
// Reset clears the control state and entry count; the cells are not cleared.
// ----------------------------------------------------------------------------
// postorder_from_push_pop_trace
// Turns an inorder push/pop trace into postorder node values using a
// shifting stack of marked entries.
// ----------------------------------------------------------------------------
module postorder_from_push_pop_trace
  import pfp_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count, count_next;
  shift_cmd_t       cmd;
  entry_t           top, second;
  logic             accept, can_emit, emit, last;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign can_emit = !out_valid || out_ready;

  pfp_chain u_chain (
    .clk        (clk),
    .cmd        (cmd),
    .push_value (in_data.node_value_in),
    .top        (top),
    .second     (second)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == MODE_POP) begin
            state_next = ST_POP;
          end else if (in_data.mode == MODE_FINISH) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_POP: begin
        if (count == '0 || !top.mark) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (count == '0 || (count == CNT_W'(1) && can_emit)) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    emit = 1'b0;
    last = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept && in_data.mode == MODE_PUSH && count < CNT_W'(STACK_DEPTH)) begin
          cmd.push = 1'b1;
        end
      end
      ST_POP: begin
        if (count != '0 && top.mark) begin
          if (can_emit) begin
            emit    = 1'b1;
            cmd.pop = 1'b1;
            // last unless the next entry down is marked too
            last    = !(count > CNT_W'(1) && second.mark);
          end
        end else if (count != '0) begin
          cmd.set_mark = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (count != '0 && can_emit) begin
          emit    = 1'b1;
          cmd.pop = 1'b1;
          last    = (count == CNT_W'(1));
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    count_next = count;
    if (cmd.push) begin
      count_next = count + CNT_W'(1);
    end else if (cmd.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= '{node_value: top.value, last_of_run: last};
    end
  end

endmodule

FILE: hw/rtl/pfp_cell.sv
// ----------------------------------------------------------------------------
// pfp_cell
// One stack slot: loads from the upper neighbor on push, from the lower
// neighbor on pop, or sets its mark.
// ----------------------------------------------------------------------------
module pfp_cell
  import pfp_pkg::*;
(
  input  logic       clk,
  input  shift_cmd_t cmd,
  input  entry_t     from_above,
  input  entry_t     from_below,
  output entry_t     entry
);

  always_ff @(posedge clk) begin
    priority if (cmd.push) begin
      entry <= from_above;
    end else if (cmd.pop) begin
      entry <= from_below;
    end else if (cmd.set_mark) begin
      entry.mark <= 1'b1;
    end else begin
      entry <= entry;
    end
  end

endmodule

FILE: hw/rtl/pfp_chain.sv
// ----------------------------------------------------------------------------
// pfp_chain
// Row of stack cells; cell 0 is the top of stack.
// ----------------------------------------------------------------------------
module pfp_chain
  import pfp_pkg::*;
(
  input  logic             clk,
  input  shift_cmd_t       cmd,
  input  logic [VAL_W-1:0] push_value,
  output entry_t           top,
  output entry_t           second
);

  entry_t cells [STACK_DEPTH];

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t     above;
    entry_t     below;
    shift_cmd_t cell_cmd;

    if (i == 0) begin : g_top
      assign above    = '{value: push_value, mark: 1'b0};
      assign cell_cmd = cmd;
    end else begin : g_mid
      assign above    = cells[i-1];
      // only the top slot is marked directly; marks reach lower slots by shifting
      assign cell_cmd = '{push: cmd.push, pop: cmd.pop, set_mark: 1'b0};
    end

    if (i == STACK_DEPTH - 1) begin : g_bot
      assign below = '0;
    end else begin : g_inner
      assign below = cells[i+1];
    end

    pfp_cell u_cell (
      .clk        (clk),
      .cmd        (cell_cmd),
      .from_above (above),
      .from_below (below),
      .entry      (cells[i])
    );
  end

  assign top    = cells[0];
  assign second = cells[1];

endmodule

FILE: test/postorder_from_push_pop_trace_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// postorder_from_push_pop_trace_test
// Feeds inorder push/pop walks of random binary trees, plus broken walks and
// noise, and checks every emitted node word against a marked-stack tracker.
// ----------------------------------------------------------------------------
module postorder_from_push_pop_trace_test;
  import pfp_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         RANDOM_ITEMS = 260;
  localparam int         QUIET_AFTER  = 200;
  localparam int         STUCK_LIMIT  = 1000;

  // Marked-stack tracker: mirrors the block's stack and queues the words
  // each accepted input should produce.
  class postorder_tracker;
    logic [VAL_W-1:0] vals [STACK_DEPTH];
    bit               marks [STACK_DEPTH];
    int               depth;
    out_word_t        expected_nodes[$];
    int               errors;

    function new();
      depth  = 0;
      errors = 0;
    endfunction

    function void pop_top();
      out_word_t w;
      depth--;
      w.node_value  = vals[depth];
      w.last_of_run = 1'b0;
      expected_nodes.push_back(w);
    endfunction

    function void note_word(in_word_t w);
      int prior_size;
      prior_size = expected_nodes.size();
      case (w.mode)
        MODE_PUSH: begin
          if (depth < STACK_DEPTH) begin
            vals[depth]  = w.node_value_in;
            marks[depth] = 1'b0;
            depth++;
          end
        end
        MODE_POP: begin
          while (depth > 0 && marks[depth-1]) pop_top();
          if (depth > 0) marks[depth-1] = 1'b1;
        end
        MODE_FINISH: begin
          while (depth > 0) pop_top();
        end
        default: ;
      endcase
      if (expected_nodes.size() > prior_size)
        expected_nodes[expected_nodes.size()-1].last_of_run = 1'b1;
    endfunction

    function void check_word(out_word_t got);
      out_word_t exp_w;
      if (expected_nodes.size() == 0) begin
        $display("%0t: unexpected word: expected none, actual value %h last %b",
                 $time, got.node_value, got.last_of_run);
        errors++;
      end else begin
        exp_w = expected_nodes.pop_front();
        if (got.node_value !== exp_w.node_value) begin
          $display("%0t: node_value mismatch: expected %h, actual %h",
                   $time, exp_w.node_value, got.node_value);
          errors++;
        end
        if (got.last_of_run !== exp_w.last_of_run) begin
          $display("%0t: last_of_run mismatch: expected %b, actual %b",
                   $time, exp_w.last_of_run, got.last_of_run);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_nodes.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  postorder_from_push_pop_trace u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  postorder_tracker tracker = new();
  bit idle_en = 1'b1;
  int sent = 0;
  int stall_left = 0;
  int stuck_cycles = 0;

  // receiver: random stall bursts, started only while idle_en is set
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 5);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_word(in_data);
      if (out_valid && out_ready) tracker.check_word(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("tb: failure");
          $finish;
        end
      end
    end
  end

  // Holds the word until accepted; valid only drops during an idle burst.
  task automatic send_word(input logic [1:0] mode, input logic [VAL_W-1:0] value);
    in_word_t w;
    w.mode          = mode;
    w.node_value_in = value;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    if (mode != MODE_UNUSED) sent++;
  endtask

  // inorder walk: push node, walk left subtree, pop, walk right subtree
  function automatic void build_walk(int n, ref in_word_t walk[$]);
    int       left;
    in_word_t w;
    if (n == 0) return;
    w.mode          = MODE_PUSH;
    w.node_value_in = VAL_W'($urandom_range(0, 65535));
    walk.push_back(w);
    left = $urandom_range(0, n - 1);
    build_walk(left, walk);
    w.mode          = MODE_POP;
    w.node_value_in = VAL_W'($urandom_range(0, 65535));
    walk.push_back(w);
    build_walk(n - 1 - left, walk);
  endfunction

  task automatic send_tree(int n, bit broken);
    in_word_t walk[$];
    int       len;
    build_walk(n, walk);
    len = broken ? $urandom_range(1, walk.size()) : walk.size();
    for (int i = 0; i < len; i++) send_word(walk[i].mode, walk[i].node_value_in);
    if (!broken || $urandom_range(0, 1))
      send_word(MODE_FINISH, VAL_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    bit paused;
    int pick;
    paused = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: empty-stack cases, unused mode, extremes, mark chains
    send_word(MODE_UNUSED, 16'hFFFF);
    send_word(MODE_POP, 16'hFFFF);
    send_word(MODE_FINISH, 16'hFFFF);
    send_word(MODE_PUSH, 16'h0000);
    send_word(MODE_PUSH, 16'hFFFF);
    send_word(MODE_POP, 16'h0000);      // top unmarked: mark only
    send_word(MODE_POP, 16'h0000);      // emits FFFF, marks 0000
    send_word(MODE_PUSH, 16'h1234);
    send_word(MODE_POP, 16'hFFFF);
    send_word(MODE_POP, 16'h8001);      // emits 1234 then 0000
    send_word(MODE_POP, 16'h0000);
    send_word(MODE_PUSH, 16'hA5A5);
    send_word(MODE_PUSH, 16'h5A5A);
    send_word(MODE_UNUSED, 16'h0000);
    send_word(MODE_FINISH, 16'h0000);
    send_word(MODE_PUSH, 16'h0007);
    send_word(MODE_POP, 16'hFFFF);
    send_word(MODE_FINISH, 16'hFFFF);

    // random walks, broken walks and noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= QUIET_AFTER) idle_en = 1'b0;
      if (!paused && sent >= RANDOM_ITEMS / 2) begin
        paused = 1'b1;
        // fill past full depth so the extra pushes get dropped
        for (int i = 0; i < STACK_DEPTH + 2; i++) send_word(MODE_PUSH, VAL_W'(16'hC000 + i));
        send_word(MODE_POP, VAL_W'($urandom_range(0, 65535)));
        send_word(MODE_POP, VAL_W'($urandom_range(0, 65535)));
        send_word(MODE_FINISH, VAL_W'($urandom_range(0, 65535)));
        // sender holds off until the flush has fully drained
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_tree($urandom_range(0, 5) == 0 ? $urandom_range(13, 30) : $urandom_range(1, 12),
                  1'b0);
      end else if (pick < 9) begin
        send_tree($urandom_range(1, 12), 1'b1);
      end else begin
        repeat ($urandom_range(1, 5))
          send_word(2'($urandom_range(0, 3)), VAL_W'($urandom_range(0, 65535)));
      end
    end
    send_word(MODE_FINISH, 16'h0000);
    in_valid <= 1'b0;

    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/pfp_pkg.sv
hw/rtl/pfp_cell.sv
hw/rtl/pfp_chain.sv
hw/rtl/postorder_from_push_pop_trace.sv
test/postorder_from_push_pop_trace_test.sv
